FILE: src/cpte_pkg.sv
`default_nettype none

package cpte_pkg;

   // cell store geometry: the cell index covers the whole store, no wrap needed
   localparam int CELL_W      = 10;
   localparam int CELL_COUNT  = 1 << CELL_W;

   // phase graph geometry, tied to the register layout
   localparam int PHASE_W         = 3;
   localparam int PHASE_COUNT     = 8;
   localparam int LINKS_PER_PHASE = 2;
   localparam int RATE_SLOTS      = 2;
   localparam int LINK_LIMIT      = (LINKS_PER_PHASE < RATE_SLOTS) ? LINKS_PER_PHASE : RATE_SLOTS;
   localparam int SLOT_W          = 5;
   localparam int TARGET_SHIFT_W  = 7;

   localparam int TIME_W  = 32;
   localparam int RATE_W  = 32;
   localparam int UNIF_W  = 32;
   localparam int PROD_W  = 64;

   // configuration register indexes
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINK_COUNT     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LINK_TARGET    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMED_LINK     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DIVIDE_MASK    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_REMOVE_MASK    = 3'd5;

   // 6.0 minutes in Q16.16
   localparam logic [TIME_W-1:0] TIME_STEP_RESET = 32'd393216;

   // 1.0 in the Q.40 product of Q16.16 and Q8.24
   localparam logic [PROD_W-1:0] FIXED_ONE = 64'h0000_0100_0000_0000;

   typedef struct packed {
      logic [TIME_W-1:0] time_step;
      logic [15:0]       link_count;
      logic [47:0]       link_target;
      logic [15:0]       timed_link;
      logic [7:0]        divide_mask;
      logic [7:0]        remove_mask;
   } cfg_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic               moved;
      logic               divide;
      logic               remove;
      logic [TIME_W-1:0]  elapsed;
   } result_type;

endpackage

`default_nettype wire

FILE: src/cpte_ram.sv
`default_nettype none

module cpte_ram #(
   parameter int WIDTH = 35,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: src/cpte_csr.sv
`default_nettype none

module cpte_csr
   import cpte_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  wr_en,
   input  wire logic [CSR_IDX_W-1:0]  wr_index,
   input  wire logic [CSR_DATA_W-1:0] wr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_TIME_STEP:      cfg_in.time_step      = wr_data[TIME_W-1:0];
            CSR_LINK_COUNT:     cfg_in.link_count     = wr_data[15:0];
            CSR_LINK_TARGET:    cfg_in.link_target    = wr_data[47:0];
            CSR_TIMED_LINK:     cfg_in.timed_link     = wr_data[15:0];
            CSR_DIVIDE_MASK:    cfg_in.divide_mask    = wr_data[7:0];
            CSR_REMOVE_MASK:    cfg_in.remove_mask    = wr_data[7:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{time_step: TIME_STEP_RESET, default: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: src/cpte_eval.sv
`default_nettype none

module cpte_eval
   import cpte_pkg::*;
(
   input  wire logic               clock,
   input  wire cfg_type            cfg,
   input  wire logic               load_item,
   input  wire logic [RATE_W-1:0]  first_rate,
   input  wire logic [RATE_W-1:0]  second_rate,
   input  wire logic [UNIF_W-1:0]  first_uniform,
   input  wire logic [UNIF_W-1:0]  second_uniform,
   input  wire logic [1:0]         arrest_mask,
   input  wire logic               load_state,
   input  wire logic [PHASE_W-1:0] stored_phase,
   input  wire logic [TIME_W-1:0]  stored_elapsed,
   input  wire logic               load_product,
   output result_type              result
);

   logic [RATE_W-1:0]  rate_ff      [RATE_SLOTS];
   logic [UNIF_W-1:0]  unif_ff      [RATE_SLOTS];
   logic [1:0]         arrest_ff;
   logic [PHASE_W-1:0] phase_ff;
   logic [TIME_W-1:0]  elapsed_ff;
   logic [TIME_W-1:0]  elapsed_in;
   logic [PROD_W-1:0]  rate_step_ff [RATE_SLOTS];
   logic [PROD_W-1:0]  age_rate_ff  [RATE_SLOTS];
   logic [RATE_SLOTS-1:0] draw_hit_ff;
   logic [RATE_SLOTS-1:0] draw_hit_in;
   logic [TIME_W:0]    elapsed_sum;

   logic [SLOT_W-1:0]         slot      [RATE_SLOTS];
   logic [TARGET_SHIFT_W-1:0] tgt_shift [RATE_SLOTS];
   logic [47:0]               tgt_word  [RATE_SLOTS];
   logic [15:0]               fix_word  [RATE_SLOTS];
   logic [15:0]               cnt_word;
   logic [1:0]                link_num;
   logic [RATE_SLOTS-1:0]     fire;
   logic                      pick;

   // saturating advance of the elapsed time
   assign elapsed_sum = {1'b0, stored_elapsed} + {1'b0, cfg.time_step};
   assign elapsed_in  = elapsed_sum[TIME_W] ? '1 : elapsed_sum[TIME_W-1:0];

   always_comb begin
      for (int k = 0; k < RATE_SLOTS; k++) begin
         draw_hit_in[k] = {unif_ff[k], 8'h00} < rate_step_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (load_item) begin
         rate_ff[0] <= first_rate;
         rate_ff[1] <= second_rate;
         unif_ff[0] <= first_uniform;
         unif_ff[1] <= second_uniform;
         arrest_ff  <= arrest_mask;
      end
      if (load_state) begin
         phase_ff   <= stored_phase;
         elapsed_ff <= elapsed_in;
         for (int k = 0; k < RATE_SLOTS; k++) begin
            rate_step_ff[k] <= PROD_W'(rate_ff[k]) * PROD_W'(cfg.time_step);
         end
      end
      if (load_product) begin
         for (int k = 0; k < RATE_SLOTS; k++) begin
            age_rate_ff[k] <= PROD_W'(elapsed_ff) * PROD_W'(rate_ff[k]);
         end
         draw_hit_ff <= draw_hit_in;
      end
   end

   // link lookup and first-firing selection
   always_comb begin
      cnt_word = cfg.link_count >> ({1'b0, phase_ff} * 4'd2);
      link_num = 2'd0;
      if (int'(phase_ff) < PHASE_COUNT) begin
         link_num = (cnt_word[1:0] > 2'(LINK_LIMIT)) ? 2'(LINK_LIMIT) : cnt_word[1:0];
      end
      for (int k = 0; k < RATE_SLOTS; k++) begin
         slot[k]      = SLOT_W'(phase_ff) * SLOT_W'(LINKS_PER_PHASE) + SLOT_W'(k);
         tgt_shift[k] = TARGET_SHIFT_W'(slot[k]) * TARGET_SHIFT_W'(3);
         tgt_word[k]  = cfg.link_target >> tgt_shift[k];
         fix_word[k]  = cfg.timed_link >> slot[k];
         fire[k] = (2'(k) < link_num) && !arrest_ff[k] &&
                   (fix_word[k][0] ? (age_rate_ff[k] > FIXED_ONE) : draw_hit_ff[k]);
      end
      pick = !fire[0];

      result.phase   = phase_ff;
      result.elapsed = elapsed_ff;
      result.moved   = 1'b0;
      result.divide  = 1'b0;
      result.remove  = 1'b0;
      if (|fire) begin
         result.divide = cfg.divide_mask[phase_ff];
         result.remove = cfg.remove_mask[phase_ff];
         if (!cfg.remove_mask[phase_ff]) begin
            result.phase   = pick ? tgt_word[1][PHASE_W-1:0] : tgt_word[0][PHASE_W-1:0];
            result.elapsed = '0;
            result.moved   = 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

FILE: src/cell_phase_transition_engine.sv
`default_nettype none

// each accepted cell walks READ, MULT and DECIDE over the dual-port state memory, then the
//   output register drives rsp_tvalid; DECIDE waits while the output is full. A new cell can
//   be accepted as the last one commits (the next read overlaps the write-back, with forwarding)
// reset: configuration registers take their defaults at once; the state memory is then
//   cleared by a pass over all cells while req_tready stays low (csr writes still taken)
module cell_phase_transition_engine
   import cpte_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // cell_index[9:0], first_rate[41:10], second_rate[73:42],
   // first_uniform[105:74], second_uniform[137:106], arrest_mask[139:138], zero pad
   input  wire logic [143:0]          req_tdata,

   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // cell_index_out[9:0], phase_out[12:10], moved[13], divide_flag[14],
   // remove_flag[15], elapsed_out[47:16]
   output logic      [47:0]           rsp_tdata,

   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   // sequencer states
   localparam logic [2:0] ST_CLEAR = 3'd0;  // sweeping the state memory to zero
   localparam logic [2:0] ST_IDLE  = 3'd1;  // waiting for a transaction
   localparam logic [2:0] ST_READ  = 3'd2;  // memory data back, advance elapsed time
   localparam logic [2:0] ST_MULT  = 3'd3;  // elapsed times rate products
   localparam logic [2:0] ST_DECIDE = 3'd4; // pick link, write back, load output

   localparam int ENTRY_W = PHASE_W + TIME_W;

   logic [2:0]        state_ff, state_in;
   logic [CELL_W-1:0] clear_cnt_ff, clear_cnt_in;
   logic [CELL_W-1:0] cell_ff, cell_in;
   logic              fwd_ff, fwd_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0] out_cell_ff;
   result_type        out_res_ff;

   cfg_type           cfg;
   result_type        result;

   logic              commit;
   logic              accept;
   logic [CELL_W-1:0] req_cell;

   logic               ram_wr_en;
   logic [CELL_W-1:0]  ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic [ENTRY_W-1:0] ram_rd_data;
   logic [PHASE_W-1:0] stored_phase;
   logic [TIME_W-1:0]  stored_elapsed;

   // configuration is always taken
   assign csr_ready = 1'b1;

   cpte_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   // a decision commits once the output register is free or being drained
   assign commit     = (state_ff == ST_DECIDE) && (!rsp_valid_ff || rsp_tready);
   assign req_tready = (state_ff == ST_IDLE) || commit;
   assign accept     = req_tvalid && req_tready;
   assign req_cell   = req_tdata[CELL_W-1:0];

   always_comb begin
      state_in     = state_ff;
      clear_cnt_in = clear_cnt_ff;
      case (state_ff)
         ST_CLEAR: begin
            clear_cnt_in = clear_cnt_ff + CELL_W'(1);
            if (clear_cnt_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ:  state_in = ST_MULT;
         ST_MULT:  state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (commit) begin
               state_in = accept ? ST_READ : ST_IDLE;
            end
         end
         default:  state_in = ST_CLEAR;
      endcase
   end

   // the new read overlaps the write-back of the same cell: take the result instead
   assign cell_in = accept ? req_cell : cell_ff;
   assign fwd_in  = accept ? (commit && (req_cell == cell_ff)) : fwd_ff;

   assign rsp_valid_in = commit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_cnt_ff <= '0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
         fwd_ff       <= fwd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
      if (commit) begin
         out_cell_ff <= cell_ff;
         out_res_ff  <= result;
      end
   end

   // state memory: phase on top, elapsed time below
   assign ram_wr_en   = (state_ff == ST_CLEAR) || commit;
   assign ram_wr_addr = (state_ff == ST_CLEAR) ? clear_cnt_ff : cell_ff;
   assign ram_wr_data = (state_ff == ST_CLEAR) ? '0 : {result.phase, result.elapsed};

   cpte_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CELL_COUNT)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (req_cell),
      .rd_data (ram_rd_data)
   );

   assign stored_phase   = fwd_ff ? out_res_ff.phase   : ram_rd_data[ENTRY_W-1:TIME_W];
   assign stored_elapsed = fwd_ff ? out_res_ff.elapsed : ram_rd_data[TIME_W-1:0];

   cpte_eval u_eval (
      .clock          (clock),
      .cfg            (cfg),
      .load_item      (accept),
      .first_rate     (req_tdata[41:10]),
      .second_rate    (req_tdata[73:42]),
      .first_uniform  (req_tdata[105:74]),
      .second_uniform (req_tdata[137:106]),
      .arrest_mask    (req_tdata[139:138]),
      .load_state     (state_ff == ST_READ),
      .stored_phase   (stored_phase),
      .stored_elapsed (stored_elapsed),
      .load_product   (state_ff == ST_MULT),
      .result         (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {out_res_ff.elapsed, out_res_ff.remove, out_res_ff.divide,
                        out_res_ff.moved, out_res_ff.phase, out_cell_ff};

   // only one cell in flight: no accept right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !(req_tvalid && req_tready))
      else $error("transaction accepted while a cell is in flight");

   // a read of the entry being written must be served by forwarding
   a_forward_hazard: assert property (@(posedge clock) disable iff (reset)
      (accept && ram_wr_en && (req_cell == ram_wr_addr)) |=> fwd_ff)
      else $error("read-during-write of same cell without forwarding");

   // a committed decision shows up on the output
   a_commit_output: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_tvalid)
      else $error("committed result not presented");

   // nothing leaves the block while the memory is being cleared
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (!rsp_tvalid && !req_tready))
      else $error("activity during clearing pass");

endmodule

`default_nettype wire
